// File: rtl/core/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, constants and helper functions of the circle segment
// pushback block.
// ----------------------------------------------------------------------------
package csp_pkg;

    localparam int COORD_WIDTH        = 24;
    localparam int RADIUS_WIDTH       = 16;
    localparam int FRAC_BITS_DEFAULT  = 8;
    localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 16'd2048;

    // projection fraction bits and square root fraction bits
    localparam int U_FRAC      = 24;
    localparam int SQRT_FRAC   = 6;

    // differences are scaled down so that products stay inside the datapath
    localparam int SCALE_SHIFT = (COORD_WIDTH > 28) ? COORD_WIDTH - 28 : 0;
    localparam int DIFF_W      = COORD_WIDTH + 1 - SCALE_SHIFT;

    function automatic int max_i(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] centre_x;
        logic signed [COORD_WIDTH-1:0] centre_y;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
        logic                          first_segment;
        logic                          last_segment;
    } in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] new_x;
        logic signed [COORD_WIDTH-1:0] new_y;
        logic                          pushed;
        logic                          entity_done;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LEN_XX,
        ST_LEN_YY,
        ST_DOT_X,
        ST_DOT_Y,
        ST_DOT_SUM,
        ST_TEST,
        ST_DIV_U,
        ST_FOOT_X,
        ST_FOOT_Y,
        ST_VEC_Y,
        ST_DIST_X,
        ST_DIST_Y,
        ST_RAD,
        ST_RAD_SUM,
        ST_HIT,
        ST_SQRT,
        ST_DEPTH,
        ST_CHECK,
        ST_PUSH_MX,
        ST_PUSH_DX,
        ST_DIV_X,
        ST_WRITE_X,
        ST_PUSH_MY,
        ST_PUSH_DY,
        ST_DIV_Y,
        ST_WRITE_Y,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_DXDX,
        MUL_DYDY,
        MUL_PXDX,
        MUL_PYDY,
        MUL_DXQ,
        MUL_DYQ,
        MUL_VXVX,
        MUL_VYVY,
        MUL_RSRS,
        MUL_MAGX_DEPTH,
        MUL_MAGY_DEPTH
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LEN_SET,
        ACT_LEN_ADD,
        ACT_DOT_SET,
        ACT_DOT_ADD,
        ACT_VX,
        ACT_VY,
        ACT_D2_SET,
        ACT_D2_ADD,
        ACT_RS2
    } act_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        act_t     act;
        logic     div_start_u;
        logic     div_start_p;
        logic     sqrt_start;
        logic     depth_calc;
        logic     write_x;
        logic     write_y;
        logic     finish;
    } cmd_t;

    typedef struct packed {
        logic test_ok;
        logic hit;
        logic depth_ok;
        logic div_busy;
        logic sqrt_busy;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/csp_div.sv
// ----------------------------------------------------------------------------
// csp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csp_div #(
    parameter int NUM_W = 74,
    parameter int DEN_W = 50
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] num_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        take     = (rem_sh >= {1'b0, den_reg});
        rem_next = take ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
        num_next = {num_reg[NUM_W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = num_reg;

endmodule

// File: rtl/core/csp_sqrt.sv
// ----------------------------------------------------------------------------
// csp_sqrt
// Floor integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module csp_sqrt #(
    parameter int RAD_W = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [RAD_W-1:0]   radicand,
    output logic               busy,
    output logic [RAD_W/2-1:0] root
);

    localparam int RT_W  = RAD_W / 2;
    localparam int CNT_W = $clog2(RT_W + 1);

    logic [RAD_W-1:0] rad_reg;
    logic [RT_W-1:0]  root_reg;
    logic [RT_W:0]    rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [RT_W+2:0]  rem_sh;
    logic [RT_W+2:0]  trial;
    logic             take;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1:RAD_W-2]};
        trial  = (RT_W+3)'({root_reg, 2'b01});
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(RT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            root_reg <= {root_reg[RT_W-2:0], take};
            rem_reg  <= take ? (RT_W+1)'(rem_sh - trial) : (RT_W+1)'(rem_sh);
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: rtl/core/csp_datapath.sv
// ----------------------------------------------------------------------------
// csp_datapath
// Held centre, radius register, shared multiplier, divider and square root.
// ----------------------------------------------------------------------------
module csp_datapath #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csp_pkg::cmd_t                      cmd,
    output csp_pkg::status_t                   status,
    input  csp_pkg::in_t                       in_data,
    input  logic                               out_stall,
    output logic                               out_valid,
    output csp_pkg::out_t                      out_data,
    input  logic                               cfg_we,
    input  logic [csp_pkg::RADIUS_WIDTH-1:0]   cfg_wdata
);

    localparam int CW   = csp_pkg::COORD_WIDTH;
    localparam int SH   = csp_pkg::SCALE_SHIFT;
    localparam int D    = csp_pkg::DIFF_W;
    localparam int UF   = csp_pkg::U_FRAC;
    localparam int SF   = csp_pkg::SQRT_FRAC;
    localparam int RADW = csp_pkg::RADIUS_WIDTH;
    localparam int RWW  = RADW + FRAC_BITS;
    localparam int RW   = 8 + FRAC_BITS;
    localparam int DPW  = RW + SF;
    localparam int QW   = UF + 1;
    localparam int VW   = D + 2;
    localparam int MW   = csp_pkg::max_i(csp_pkg::max_i(VW, QW + 1), DPW + 1);
    localparam int PW   = 2 * MW;
    localparam int LW   = 2 * D;
    localparam int DTW  = 2 * D + 1;
    localparam int D2W  = 2 * D + 2;
    localparam int SQW  = D2W + 2 * SF;
    localparam int RTW  = SQW / 2;
    localparam int CMPW = csp_pkg::max_i(D2W, 2 * RW);
    localparam int DVW  = csp_pkg::max_i(LW, RTW);
    localparam int NW   = csp_pkg::max_i(LW + UF, VW + DPW + 1);
    localparam int EW   = NW + SH + 2;

    localparam logic signed [PW-1:0] HALF_U = PW'(1) << (UF - 1);
    localparam logic signed [EW-1:0] SAT_HI = (EW'(1) << (CW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

    logic [RADW-1:0]         radius_reg;
    logic signed [CW-1:0]    held_x_reg;
    logic signed [CW-1:0]    held_y_reg;
    logic signed [CW-1:0]    nx_reg;
    logic signed [CW-1:0]    ny_reg;
    logic                    last_reg;
    logic signed [D-1:0]     dx_reg;
    logic signed [D-1:0]     dy_reg;
    logic signed [D-1:0]     px_reg;
    logic signed [D-1:0]     py_reg;
    logic [LW-1:0]           len2_reg;
    logic signed [DTW-1:0]   dot_reg;
    logic signed [VW-1:0]    vx_reg;
    logic signed [VW-1:0]    vy_reg;
    logic [D2W-1:0]          d2_reg;
    logic [2*RW-1:0]         rs2_reg;
    logic signed [DPW:0]     depth_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    out_valid_reg;
    csp_pkg::out_t           out_reg;

    logic signed [CW-1:0]    cx_sel;
    logic signed [CW-1:0]    cy_sel;
    logic signed [CW:0]      dx_full;
    logic signed [CW:0]      dy_full;
    logic signed [CW:0]      px_full;
    logic signed [CW:0]      py_full;
    logic [RWW-1:0]          rs_wide;
    logic [RW-1:0]           rs;
    logic signed [MW-1:0]    mul_a;
    logic signed [MW-1:0]    mul_b;
    logic [VW-1:0]           mag_x;
    logic [VW-1:0]           mag_y;
    logic signed [PW-1:0]    ox_full;
    logic signed [VW-1:0]    v_calc;
    logic                    div_start;
    logic [NW-1:0]           div_num;
    logic [DVW-1:0]          div_den;
    logic                    div_busy;
    logic [NW-1:0]           div_quo;
    logic [QW-1:0]           q_u;
    logic                    sqrt_busy;
    logic [RTW-1:0]          root;
    logic signed [EW-1:0]    push_e;
    logic signed [EW-1:0]    cx_e;
    logic signed [EW-1:0]    cy_e;
    logic signed [EW-1:0]    new_x_e;
    logic signed [EW-1:0]    new_y_e;
    logic signed [CW-1:0]    new_x_sat;
    logic signed [CW-1:0]    new_y_sat;

    // centre and differences for the load
    always_comb
    begin
        cx_sel  = in_data.first_segment ? in_data.centre_x : held_x_reg;
        cy_sel  = in_data.first_segment ? in_data.centre_y : held_y_reg;
        dx_full = (CW+1)'(in_data.end_x) - (CW+1)'(in_data.start_x);
        dy_full = (CW+1)'(in_data.end_y) - (CW+1)'(in_data.start_y);
        px_full = (CW+1)'(cx_sel) - (CW+1)'(in_data.start_x);
        py_full = (CW+1)'(cy_sel) - (CW+1)'(in_data.start_y);
    end

    always_comb
    begin
        rs_wide = RWW'(radius_reg) << FRAC_BITS;
        rs      = RW'(rs_wide >> (8 + SH));
        mag_x   = (vx_reg < 0) ? VW'(-vx_reg) : VW'(vx_reg);
        mag_y   = (vy_reg < 0) ? VW'(-vy_reg) : VW'(vy_reg);
        q_u     = QW'(div_quo);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            csp_pkg::MUL_DXDX:
            begin
                mul_a = MW'(dx_reg);
                mul_b = MW'(dx_reg);
            end
            csp_pkg::MUL_DYDY:
            begin
                mul_a = MW'(dy_reg);
                mul_b = MW'(dy_reg);
            end
            csp_pkg::MUL_PXDX:
            begin
                mul_a = MW'(px_reg);
                mul_b = MW'(dx_reg);
            end
            csp_pkg::MUL_PYDY:
            begin
                mul_a = MW'(py_reg);
                mul_b = MW'(dy_reg);
            end
            csp_pkg::MUL_DXQ:
            begin
                mul_a = MW'(dx_reg);
                mul_b = $signed(MW'(q_u));
            end
            csp_pkg::MUL_DYQ:
            begin
                mul_a = MW'(dy_reg);
                mul_b = $signed(MW'(q_u));
            end
            csp_pkg::MUL_VXVX:
            begin
                mul_a = MW'(vx_reg);
                mul_b = MW'(vx_reg);
            end
            csp_pkg::MUL_VYVY:
            begin
                mul_a = MW'(vy_reg);
                mul_b = MW'(vy_reg);
            end
            csp_pkg::MUL_RSRS:
            begin
                mul_a = $signed(MW'(rs));
                mul_b = $signed(MW'(rs));
            end
            csp_pkg::MUL_MAGX_DEPTH:
            begin
                mul_a = $signed(MW'(mag_x));
                mul_b = MW'(depth_reg);
            end
            csp_pkg::MUL_MAGY_DEPTH:
            begin
                mul_a = $signed(MW'(mag_y));
                mul_b = MW'(depth_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // foot point offset minus centre offset
    always_comb
    begin
        ox_full = (prod_reg + HALF_U) >>> UF;
        if (cmd.act == csp_pkg::ACT_VY)
        begin
            v_calc = VW'(ox_full) - VW'(py_reg);
        end
        else
        begin
            v_calc = VW'(ox_full) - VW'(px_reg);
        end
    end

    // divider operands
    always_comb
    begin
        div_start = cmd.div_start_u | cmd.div_start_p;
        if (cmd.div_start_u)
        begin
            div_num = NW'($unsigned(dot_reg)) << UF;
            div_den = DVW'(len2_reg);
        end
        else
        begin
            div_num = NW'($unsigned(NW'(prod_reg))) + NW'(root >> 1);
            div_den = DVW'(root);
        end
    end

    // apply the push and saturate
    always_comb
    begin
        push_e  = $signed(EW'(div_quo)) <<< SH;
        cx_e    = EW'(held_x_reg);
        cy_e    = EW'(held_y_reg);
        new_x_e = (vx_reg < 0) ? cx_e + push_e : cx_e - push_e;
        new_y_e = (vy_reg < 0) ? cy_e + push_e : cy_e - push_e;
        if (new_x_e > SAT_HI)
        begin
            new_x_sat = CW'(SAT_HI);
        end
        else if (new_x_e < SAT_LO)
        begin
            new_x_sat = CW'(SAT_LO);
        end
        else
        begin
            new_x_sat = CW'(new_x_e);
        end
        if (new_y_e > SAT_HI)
        begin
            new_y_sat = CW'(SAT_HI);
        end
        else if (new_y_e < SAT_LO)
        begin
            new_y_sat = CW'(SAT_LO);
        end
        else
        begin
            new_y_sat = CW'(new_y_e);
        end
    end

    csp_div #(
        .NUM_W (NW),
        .DEN_W (DVW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    csp_sqrt #(
        .RAD_W (SQW)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.sqrt_start),
        .radicand (SQW'(d2_reg) << (2 * SF)),
        .busy     (sqrt_busy),
        .root     (root)
    );

    // control state: radius, held centre, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= csp_pkg::RADIUS_RESET;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            if (cmd.load && in_data.first_segment)
            begin
                held_x_reg <= in_data.centre_x;
                held_y_reg <= in_data.centre_y;
            end
            else if (cmd.finish)
            begin
                held_x_reg <= nx_reg;
                held_y_reg <= ny_reg;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load)
        begin
            dx_reg   <= D'(dx_full >>> SH);
            dy_reg   <= D'(dy_full >>> SH);
            px_reg   <= D'(px_full >>> SH);
            py_reg   <= D'(py_full >>> SH);
            nx_reg   <= cx_sel;
            ny_reg   <= cy_sel;
            last_reg <= in_data.last_segment;
        end
        case (cmd.act)
            csp_pkg::ACT_LEN_SET: len2_reg <= LW'(prod_reg);
            csp_pkg::ACT_LEN_ADD: len2_reg <= len2_reg + LW'(prod_reg);
            csp_pkg::ACT_DOT_SET: dot_reg  <= DTW'(prod_reg);
            csp_pkg::ACT_DOT_ADD: dot_reg  <= dot_reg + DTW'(prod_reg);
            csp_pkg::ACT_VX:      vx_reg   <= v_calc;
            csp_pkg::ACT_VY:      vy_reg   <= v_calc;
            csp_pkg::ACT_D2_SET:  d2_reg   <= D2W'(prod_reg);
            csp_pkg::ACT_D2_ADD:  d2_reg   <= d2_reg + D2W'(prod_reg);
            csp_pkg::ACT_RS2:     rs2_reg  <= (2*RW)'(prod_reg);
            default:
            begin
            end
        endcase
        if (cmd.depth_calc)
        begin
            depth_reg <= $signed((DPW+1)'(rs) << SF) - $signed((DPW+1)'(root));
        end
        if (cmd.write_x)
        begin
            nx_reg <= new_x_sat;
        end
        if (cmd.write_y)
        begin
            ny_reg <= new_y_sat;
        end
        if (cmd.finish)
        begin
            out_reg.new_x       <= nx_reg;
            out_reg.new_y       <= ny_reg;
            out_reg.pushed      <= (nx_reg != held_x_reg) || (ny_reg != held_y_reg);
            out_reg.entity_done <= last_reg;
        end
    end

    always_comb
    begin
        status.test_ok   = (len2_reg != '0) && (dot_reg > 0)
                           && (dot_reg <= $signed({1'b0, len2_reg}));
        status.hit       = (d2_reg != '0) && (CMPW'(d2_reg) < CMPW'(rs2_reg));
        status.depth_ok  = (root != '0) && (depth_reg > 0);
        status.div_busy  = div_busy;
        status.sqrt_busy = sqrt_busy;
        status.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// File: rtl/core/csp_ctrl.sv
// ----------------------------------------------------------------------------
// csp_ctrl
// Sequencer that steps the datapath through one segment transaction.
// ----------------------------------------------------------------------------
module csp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  csp_pkg::status_t  status,
    output csp_pkg::cmd_t     cmd
);

    csp_pkg::ctrl_state_t state_reg;
    csp_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = csp_pkg::ST_LEN_XX;
                end
            end
            csp_pkg::ST_LEN_XX:  state_next = csp_pkg::ST_LEN_YY;
            csp_pkg::ST_LEN_YY:  state_next = csp_pkg::ST_DOT_X;
            csp_pkg::ST_DOT_X:   state_next = csp_pkg::ST_DOT_Y;
            csp_pkg::ST_DOT_Y:   state_next = csp_pkg::ST_DOT_SUM;
            csp_pkg::ST_DOT_SUM: state_next = csp_pkg::ST_TEST;
            csp_pkg::ST_TEST:
            begin
                state_next = status.test_ok ? csp_pkg::ST_DIV_U : csp_pkg::ST_FINISH;
            end
            csp_pkg::ST_DIV_U:
            begin
                if (!status.div_busy)
                begin
                    state_next = csp_pkg::ST_FOOT_X;
                end
            end
            csp_pkg::ST_FOOT_X:  state_next = csp_pkg::ST_FOOT_Y;
            csp_pkg::ST_FOOT_Y:  state_next = csp_pkg::ST_VEC_Y;
            csp_pkg::ST_VEC_Y:   state_next = csp_pkg::ST_DIST_X;
            csp_pkg::ST_DIST_X:  state_next = csp_pkg::ST_DIST_Y;
            csp_pkg::ST_DIST_Y:  state_next = csp_pkg::ST_RAD;
            csp_pkg::ST_RAD:     state_next = csp_pkg::ST_RAD_SUM;
            csp_pkg::ST_RAD_SUM: state_next = csp_pkg::ST_HIT;
            csp_pkg::ST_HIT:
            begin
                state_next = status.hit ? csp_pkg::ST_SQRT : csp_pkg::ST_FINISH;
            end
            csp_pkg::ST_SQRT:
            begin
                if (!status.sqrt_busy)
                begin
                    state_next = csp_pkg::ST_DEPTH;
                end
            end
            csp_pkg::ST_DEPTH:   state_next = csp_pkg::ST_CHECK;
            csp_pkg::ST_CHECK:
            begin
                state_next = status.depth_ok ? csp_pkg::ST_PUSH_MX : csp_pkg::ST_FINISH;
            end
            csp_pkg::ST_PUSH_MX: state_next = csp_pkg::ST_PUSH_DX;
            csp_pkg::ST_PUSH_DX: state_next = csp_pkg::ST_DIV_X;
            csp_pkg::ST_DIV_X:
            begin
                if (!status.div_busy)
                begin
                    state_next = csp_pkg::ST_WRITE_X;
                end
            end
            csp_pkg::ST_WRITE_X: state_next = csp_pkg::ST_PUSH_MY;
            csp_pkg::ST_PUSH_MY: state_next = csp_pkg::ST_PUSH_DY;
            csp_pkg::ST_PUSH_DY: state_next = csp_pkg::ST_DIV_Y;
            csp_pkg::ST_DIV_Y:
            begin
                if (!status.div_busy)
                begin
                    state_next = csp_pkg::ST_WRITE_Y;
                end
            end
            csp_pkg::ST_WRITE_Y: state_next = csp_pkg::ST_FINISH;
            csp_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = csp_pkg::ST_IDLE;
                end
            end
            default:             state_next = csp_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = csp_pkg::MUL_NONE;
        cmd.act      = csp_pkg::ACT_NONE;
        in_stall     = 1'b1;
        case (state_reg)
            csp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            csp_pkg::ST_LEN_XX:
            begin
                cmd.mul_sel = csp_pkg::MUL_DXDX;
            end
            csp_pkg::ST_LEN_YY:
            begin
                cmd.mul_sel = csp_pkg::MUL_DYDY;
                cmd.act     = csp_pkg::ACT_LEN_SET;
            end
            csp_pkg::ST_DOT_X:
            begin
                cmd.mul_sel = csp_pkg::MUL_PXDX;
                cmd.act     = csp_pkg::ACT_LEN_ADD;
            end
            csp_pkg::ST_DOT_Y:
            begin
                cmd.mul_sel = csp_pkg::MUL_PYDY;
                cmd.act     = csp_pkg::ACT_DOT_SET;
            end
            csp_pkg::ST_DOT_SUM:
            begin
                cmd.act = csp_pkg::ACT_DOT_ADD;
            end
            csp_pkg::ST_TEST:
            begin
                cmd.div_start_u = status.test_ok;
            end
            csp_pkg::ST_FOOT_X:
            begin
                cmd.mul_sel = csp_pkg::MUL_DXQ;
            end
            csp_pkg::ST_FOOT_Y:
            begin
                cmd.mul_sel = csp_pkg::MUL_DYQ;
                cmd.act     = csp_pkg::ACT_VX;
            end
            csp_pkg::ST_VEC_Y:
            begin
                cmd.act = csp_pkg::ACT_VY;
            end
            csp_pkg::ST_DIST_X:
            begin
                cmd.mul_sel = csp_pkg::MUL_VXVX;
            end
            csp_pkg::ST_DIST_Y:
            begin
                cmd.mul_sel = csp_pkg::MUL_VYVY;
                cmd.act     = csp_pkg::ACT_D2_SET;
            end
            csp_pkg::ST_RAD:
            begin
                cmd.mul_sel = csp_pkg::MUL_RSRS;
                cmd.act     = csp_pkg::ACT_D2_ADD;
            end
            csp_pkg::ST_RAD_SUM:
            begin
                cmd.act = csp_pkg::ACT_RS2;
            end
            csp_pkg::ST_HIT:
            begin
                cmd.sqrt_start = status.hit;
            end
            csp_pkg::ST_DEPTH:
            begin
                cmd.depth_calc = 1'b1;
            end
            csp_pkg::ST_PUSH_MX:
            begin
                cmd.mul_sel = csp_pkg::MUL_MAGX_DEPTH;
            end
            csp_pkg::ST_PUSH_DX:
            begin
                cmd.div_start_p = 1'b1;
            end
            csp_pkg::ST_WRITE_X:
            begin
                cmd.write_x = 1'b1;
            end
            csp_pkg::ST_PUSH_MY:
            begin
                cmd.mul_sel = csp_pkg::MUL_MAGY_DEPTH;
            end
            csp_pkg::ST_PUSH_DY:
            begin
                cmd.div_start_p = 1'b1;
            end
            csp_pkg::ST_WRITE_Y:
            begin
                cmd.write_y = 1'b1;
            end
            csp_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/core/circle_segment_pushback.sv
// ----------------------------------------------------------------------------
// circle_segment_pushback
// Pushes a circle centre out of one wall segment per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one wall segment; on first_segment it also
// loads the circle centre, which is then held and updated segment by segment.
// Every transaction yields exactly one result: the centre after this segment,
// saturated, a pushed flag and entity_done (a copy of last_segment). The block
// works on one transaction at a time. A segment that misses the projection test
// goes straight to its result; one whose projection lands uses the shared
// divider for the projection and then the distance arithmetic and hit test; a
// hit adds the square root and depth check, and a real push adds two more
// divisions, one per axis, in the shared restoring divider (74 quotient bits,
// one per cycle). A stalled result holds back the block only when the next
// result is ready. A finished result waits in an output register, so the next
// transaction is taken while the previous result is still stalled.
// circle_radius is written through cfg_we/cfg_wdata; it resets to 8.0. The
// user must write it only while the block is idle, which is not enforced.
// ----------------------------------------------------------------------------
module circle_segment_pushback #(
    parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  csp_pkg::in_t                     in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output csp_pkg::out_t                    out_data,
    input  logic                             cfg_we,
    input  logic [csp_pkg::RADIUS_WIDTH-1:0] cfg_wdata
);

    // command and status between sequencer and datapath
    csp_pkg::cmd_t    cmd;
    csp_pkg::status_t status;

    // sequencer: hold the input stalled until the transaction is retired
    csp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: held centre, radius, multiplier, divider, square root
    csp_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

endmodule
